// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipv4lpm assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipv4lpm assertion failed");

`endif

// ===== src/ipv4lpm_pkg.sv =====
// Types and constants of the IPv4 longest-prefix-match engine.
package ipv4lpm_pkg;

    localparam int IN_ADDR_W = 32;
    localparam int PLEN_W    = 6;
    localparam int HOP_W     = 32;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_INS_WALK,
        S_INS_CHECK,
        S_INS_MARK,
        S_INS_LINK,
        S_INS_CREATE,
        S_DONE
    } t_state;

endpackage

// ===== src/ipv4_longest_prefix_match.sv =====
// Routing table on a one-bit binary trie: insert prefixes, look up longest match.
//
// Input channel (i_valid/o_ready): one item per handshake. i_mode selects
// insert (store i_next_hop under the first i_prefix_len bits of i_address)
// or lookup (walk i_address and return the deepest stored hop).
// Output channel (o_valid/i_ready): one result per item, in order:
// o_result_hop, o_hit (lookup matched), o_status (insert rejected, full).
// The engine walks the trie one address bit per cycle; node memory reads
// are registered, which sets that pace, and node storage is NODE_COUNT entries.
// Lookup: the walk stops at the last address bit or a missing child, then
// the result is registered. Insert: existing levels are walked, then a
// check step rejects a full table or leads to a mark step, or to a link
// step plus one create step per new node. One item is processed at a time;
// the next item is taken in the cycle after the previous result is registered.
// A finished result sits in an output register; if the receiver stalls the
// next item is still accepted and worked on, and only its own result waits
// until the register frees up.
// Reset (synchronous, active low) empties the table to the root node alone;
// no clearing pass is needed since every new node is written on allocation.
module ipv4_longest_prefix_match #(
    parameter int NODE_COUNT = 1024,
    parameter int ADDR_BITS  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_mode,
    input  logic [ipv4lpm_pkg::IN_ADDR_W-1:0] i_address,
    input  logic [ipv4lpm_pkg::PLEN_W-1:0]    i_prefix_len,
    input  logic [ipv4lpm_pkg::HOP_W-1:0]     i_next_hop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ipv4lpm_pkg::HOP_W-1:0]     o_result_hop,
    output logic                              o_hit,
    output logic                              o_status
);

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int DEPTH_W = $clog2(ADDR_BITS + 1);
    localparam int USED_W  = NODE_W + 1;
    localparam int SUM_W   = NODE_W + 2;
    localparam int HOP_W   = ipv4lpm_pkg::HOP_W;

    // control
    ipv4lpm_pkg::t_state r_state, n_state;
    logic [USED_W-1:0]   r_used, n_used;
    logic [NODE_W-1:0]   r_root_c0, n_root_c0;
    logic [NODE_W-1:0]   r_root_c1, n_root_c1;
    logic                r_root_has, n_root_has;
    logic                r_out_valid, n_out_valid;

    // item work registers
    logic [NODE_W-1:0]    r_node, n_node;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic [DEPTH_W-1:0]   r_len, n_len;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [HOP_W-1:0]     r_hop, n_hop;
    logic [HOP_W-1:0]     r_best, n_best;
    logic                 r_found, n_found;
    logic                 r_status, n_status;
    logic [HOP_W-1:0]     r_root_hop, n_root_hop;
    logic [HOP_W-1:0]     r_out_hop, n_out_hop;
    logic                 r_out_hit, n_out_hit;
    logic                 r_out_status, n_out_status;

    // node memories; entry 0 (root) lives in flip-flops
    logic [NODE_W-1:0] r_child_zero [NODE_COUNT];
    logic [NODE_W-1:0] r_child_one  [NODE_COUNT];
    logic              r_has_route  [NODE_COUNT];
    logic [HOP_W-1:0]  r_route_hop  [NODE_COUNT];
    logic [NODE_W-1:0] r_rd_c0, r_rd_c1;
    logic              r_rd_has;
    logic [HOP_W-1:0]  r_rd_hop;

    logic [NODE_W-1:0] w_rd_addr;
    logic [NODE_W-1:0] w_wr_addr;
    logic              w_we_c0, w_we_c1, w_we_has, w_we_hop;
    logic [NODE_W-1:0] w_wr_c0, w_wr_c1;
    logic              w_wr_has;
    logic [HOP_W-1:0]  w_wr_hop;

    logic              w_at_root;
    logic [NODE_W-1:0] w_cur_c0, w_cur_c1, w_child, w_fresh, w_fresh_next;
    logic              w_cur_has;
    logic [HOP_W-1:0]  w_cur_hop;
    logic              w_bit, w_at_max, w_at_len, w_full;
    logic [DEPTH_W-1:0] w_need;
    logic [SUM_W-1:0]  w_sum;

    assign w_at_root    = (r_node == '0);
    assign w_cur_c0     = w_at_root ? r_root_c0  : r_rd_c0;
    assign w_cur_c1     = w_at_root ? r_root_c1  : r_rd_c1;
    assign w_cur_has    = w_at_root ? r_root_has : r_rd_has;
    assign w_cur_hop    = w_at_root ? r_root_hop : r_rd_hop;
    assign w_bit        = r_addr[ADDR_BITS-1];
    assign w_child      = w_bit ? w_cur_c1 : w_cur_c0;
    assign w_at_max     = (r_depth == DEPTH_W'(ADDR_BITS));
    assign w_at_len     = (r_depth == r_len);
    assign w_need       = r_len - r_depth;
    assign w_fresh      = r_used[NODE_W-1:0];
    assign w_fresh_next = w_fresh + 1'b1;
    assign w_sum        = SUM_W'(r_used) + SUM_W'(w_need);
    assign w_full       = (w_sum > SUM_W'(NODE_COUNT));

    assign o_ready      = (r_state == ipv4lpm_pkg::S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_result_hop = r_out_hop;
    assign o_hit        = r_out_hit;
    assign o_status     = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_root_c0    = r_root_c0;
        n_root_c1    = r_root_c1;
        n_root_has   = r_root_has;
        n_root_hop   = r_root_hop;
        n_out_valid  = r_out_valid;
        n_out_hop    = r_out_hop;
        n_out_hit    = r_out_hit;
        n_out_status = r_out_status;
        n_node       = r_node;
        n_depth      = r_depth;
        n_len        = r_len;
        n_addr       = r_addr;
        n_hop        = r_hop;
        n_best       = r_best;
        n_found      = r_found;
        n_status     = r_status;

        w_rd_addr = w_child;
        w_wr_addr = r_node;
        w_we_c0   = 1'b0;
        w_we_c1   = 1'b0;
        w_we_has  = 1'b0;
        w_we_hop  = 1'b0;
        w_wr_c0   = w_fresh;
        w_wr_c1   = w_fresh;
        w_wr_has  = 1'b1;
        w_wr_hop  = r_hop;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ipv4lpm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_addr   = ADDR_BITS'(i_address);
                    n_hop    = i_next_hop;
                    n_node   = '0;
                    n_depth  = '0;
                    n_best   = '0;
                    n_found  = 1'b0;
                    n_status = ipv4lpm_pkg::STATUS_DONE;
                    if (int'(i_prefix_len) > ADDR_BITS) begin
                        n_len = DEPTH_W'(ADDR_BITS);
                    end else begin
                        n_len = DEPTH_W'(i_prefix_len);
                    end
                    n_state = (i_mode == ipv4lpm_pkg::MODE_LOOKUP) ?
                              ipv4lpm_pkg::S_LOOKUP : ipv4lpm_pkg::S_INS_WALK;
                end
            end
            ipv4lpm_pkg::S_LOOKUP: begin
                if (w_cur_has) begin
                    n_best  = w_cur_hop;
                    n_found = 1'b1;
                end
                if (w_at_max || w_child == '0) begin
                    n_state = ipv4lpm_pkg::S_DONE;
                end else begin
                    n_node  = w_child;
                    n_depth = r_depth + 1'b1;
                    n_addr  = {r_addr[ADDR_BITS-2:0], 1'b0};
                end
            end
            ipv4lpm_pkg::S_INS_WALK: begin
                if (w_at_len || w_child == '0) begin
                    n_state = ipv4lpm_pkg::S_INS_CHECK;
                end else begin
                    n_node  = w_child;
                    n_depth = r_depth + 1'b1;
                    n_addr  = {r_addr[ADDR_BITS-2:0], 1'b0};
                end
            end
            ipv4lpm_pkg::S_INS_CHECK: begin
                priority if (w_full) begin
                    n_status = ipv4lpm_pkg::STATUS_FULL;
                    n_state  = ipv4lpm_pkg::S_DONE;
                end else if (w_need == '0) begin
                    n_state = ipv4lpm_pkg::S_INS_MARK;
                end else begin
                    n_state = ipv4lpm_pkg::S_INS_LINK;
                end
            end
            ipv4lpm_pkg::S_INS_MARK: begin
                // prefix already has its node: set or overwrite its route
                if (w_at_root) begin
                    n_root_has = 1'b1;
                    n_root_hop = r_hop;
                end else begin
                    w_we_has = 1'b1;
                    w_we_hop = 1'b1;
                end
                n_state = ipv4lpm_pkg::S_DONE;
            end
            ipv4lpm_pkg::S_INS_LINK: begin
                // hang the first new node under the deepest existing one
                if (w_at_root) begin
                    if (w_bit) begin
                        n_root_c1 = w_fresh;
                    end else begin
                        n_root_c0 = w_fresh;
                    end
                end else begin
                    w_we_c1 = w_bit;
                    w_we_c0 = !w_bit;
                end
                n_depth = r_depth + 1'b1;
                n_addr  = {r_addr[ADDR_BITS-2:0], 1'b0};
                n_state = ipv4lpm_pkg::S_INS_CREATE;
            end
            ipv4lpm_pkg::S_INS_CREATE: begin
                // new node written whole: its one child is the next new node, or, for the last one, its route
                w_wr_addr = w_fresh;
                w_we_c0   = 1'b1;
                w_we_c1   = 1'b1;
                w_we_has  = 1'b1;
                w_we_hop  = 1'b1;
                w_wr_c0   = (!w_at_len && !w_bit) ? w_fresh_next : '0;
                w_wr_c1   = (!w_at_len && w_bit)  ? w_fresh_next : '0;
                w_wr_has  = w_at_len;
                w_wr_hop  = w_at_len ? r_hop : '0;
                n_used    = r_used + 1'b1;
                if (w_at_len) begin
                    n_state = ipv4lpm_pkg::S_DONE;
                end else begin
                    n_depth = r_depth + 1'b1;
                    n_addr  = {r_addr[ADDR_BITS-2:0], 1'b0};
                end
            end
            ipv4lpm_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_hop    = r_best;
                    n_out_hit    = r_found;
                    n_out_status = r_status;
                    n_state      = ipv4lpm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ipv4lpm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ipv4lpm_pkg::S_IDLE;
            r_used      <= USED_W'(1);
            r_root_c0   <= '0;
            r_root_c1   <= '0;
            r_root_has  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_root_c0   <= n_root_c0;
            r_root_c1   <= n_root_c1;
            r_root_has  <= n_root_has;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node       <= n_node;
        r_depth      <= n_depth;
        r_len        <= n_len;
        r_addr       <= n_addr;
        r_hop        <= n_hop;
        r_best       <= n_best;
        r_found      <= n_found;
        r_status     <= n_status;
        r_root_hop   <= n_root_hop;
        r_out_hop    <= n_out_hop;
        r_out_hit    <= n_out_hit;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (w_we_c0) begin
            r_child_zero[w_wr_addr] <= w_wr_c0;
        end
        if (w_we_c1) begin
            r_child_one[w_wr_addr] <= w_wr_c1;
        end
        if (w_we_has) begin
            r_has_route[w_wr_addr] <= w_wr_has;
        end
        if (w_we_hop) begin
            r_route_hop[w_wr_addr] <= w_wr_hop;
        end
        r_rd_c0  <= r_child_zero[w_rd_addr];
        r_rd_c1  <= r_child_one[w_rd_addr];
        r_rd_has <= r_has_route[w_rd_addr];
        r_rd_hop <= r_route_hop[w_rd_addr];
    end

endmodule

// ===== src/ipv4lpm_checker.sv =====
// Port-level assertions for the longest-prefix-match engine, and their bind.
`include "assert_macros.svh"

module ipv4lpm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [ipv4lpm_pkg::HOP_W-1:0] o_result_hop,
    input  logic                          o_hit,
    input  logic                          o_status
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_result_hop) && $stable(o_hit) && $stable(o_status))

    // a matching lookup never reports a full store
    `ASSERT_IMPLY(a_hit_no_full, i_clk, i_rst_n, o_valid && o_hit, o_status == ipv4lpm_pkg::STATUS_DONE)

    // no match means a zero hop
    `ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, o_valid && !o_hit, o_result_hop == '0)

    // one item at a time: the engine is busy right after taking an item
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule

bind ipv4_longest_prefix_match ipv4lpm_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_result_hop (o_result_hop),
    .o_hit        (o_hit),
    .o_status     (o_status)
);
